// ===== design/ctb_pkg.sv =====
// Shared constants, codes and the token type for the countdown timer bank.
package ctb_pkg;

  localparam int NUM_SLOTS = 16;

  localparam logic [15:0] TICK_PERIOD_RESET = 16'd500;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_QUERY  = 3'd1,
    OP_REMOVE = 3'd2,
    OP_RESET  = 3'd3,
    OP_TICK   = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // Operation travelling down the row of slot cells.
  typedef struct packed {
    logic        valid;
    logic [2:0]  op;
    logic [15:0] timer_id;
    logic [31:0] duration_ms;
    logic [15:0] new_id;
    logic        done;
    logic [31:0] remaining_ms;
    logic        finished;
  } tok_t;

endpackage

// ===== design/ctb_cell.sv =====
// One timer slot: applies the passing operation to its slot and hands it on.
module ctb_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  logic [15:0]   tick_period,
  input  ctb_pkg::tok_t tok_in,
  output ctb_pkg::tok_t tok_out
);
  import ctb_pkg::*;

  logic        slot_valid;
  logic [15:0] slot_id;
  logic [31:0] slot_time;

  logic        slot_valid_next;
  logic [31:0] slot_time_next;
  logic        load_id;
  tok_t        tok_next;

  logic        match;
  logic [31:0] period_ext;

  assign match      = slot_valid && (slot_id == tok_in.timer_id);
  assign period_ext = {16'd0, tick_period};

  always_comb begin
    slot_valid_next = slot_valid;
    slot_time_next  = slot_time;
    load_id         = 1'b0;
    tok_next        = tok_in;
    unique case (tok_in.op)
      OP_ADD: begin
        if (!tok_in.done && !slot_valid) begin
          slot_valid_next = 1'b1;
          slot_time_next  = tok_in.duration_ms;
          load_id         = 1'b1;
          tok_next.done   = 1'b1;
        end
      end
      OP_QUERY: begin
        if (!tok_in.done && match) begin
          tok_next.done         = 1'b1;
          tok_next.remaining_ms = slot_time;
          tok_next.finished     = (slot_time == 32'd0);
        end
      end
      OP_REMOVE: begin
        if (!tok_in.done && match) begin
          slot_valid_next = 1'b0;
          tok_next.done   = 1'b1;
        end
      end
      OP_RESET: begin
        // every matching slot reloads, duplicates included
        if (match) begin
          slot_time_next = tok_in.duration_ms;
          tok_next.done  = 1'b1;
        end
      end
      OP_TICK: begin
        if (slot_valid) begin
          slot_time_next = (slot_time > period_ext) ? slot_time - period_ext : 32'd0;
        end
      end
      OP_CLEAR: begin
        slot_valid_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid    <= 1'b0;
      tok_out.valid <= 1'b0;
    end else if (advance) begin
      tok_out <= tok_next;
      if (tok_in.valid) begin
        slot_valid <= slot_valid_next;
        slot_time  <= slot_time_next;
        if (load_id) begin
          slot_id <= tok_in.new_id;
        end
      end
    end
  end

endmodule

// ===== design/countdown_timer_bank.sv =====
// Top level of the countdown timer bank: entry stage, row of slot cells, result register.
//
// Input channel (in_valid/in_stall): op, timer_id, duration_ms. A transfer happens
// when in_valid is high and in_stall low. Output channel (out_valid/out_stall):
// status, new_id, remaining_ms, finished, one result per input item, in order.
// Configuration: cfg_valid/cfg_ready write cfg_data to tick_period_ms; cfg_ready
// is always high. Write it only while no item is in flight.
// Each item enters an entry register and then walks the row of NUM_SLOTS cells,
// one cell per cycle; every cell applies it to its own slot. Lowest slot first
// decides add, query and remove.
// The block takes no new item while one walks the row; the next item is taken as
// soon as the previous result sits in the output register, even if that result is
// still stalled. If the output stalls while a new result reaches the end of the
// row, the row freezes until the register frees up.
// Reset: all slots empty, id counter zero, tick period 500 ms.
module countdown_timer_bank (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  op,
  input  logic [15:0] timer_id,
  input  logic [31:0] duration_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [15:0] new_id,
  output logic [31:0] remaining_ms,
  output logic        finished,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import ctb_pkg::*;

  logic [15:0] tick_period;
  logic [15:0] id_counter;
  logic        busy;

  tok_t        entry_tok;
  tok_t        tok [NUM_SLOTS+1];
  tok_t        tail;
  logic        advance;
  logic        land;
  logic        accept;
  logic [NUM_SLOTS:0] tok_valids;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign accept    = in_valid && !busy;
  assign tok[0]    = entry_tok;
  assign tail      = tok[NUM_SLOTS];
  assign advance   = !(tail.valid && out_valid && out_stall);
  assign land      = tail.valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period <= TICK_PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tick_period <= cfg_data;
    end
  end

  // entry stage
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_tok.valid <= 1'b0;
    end else if (accept) begin
      entry_tok.valid        <= 1'b1;
      entry_tok.op           <= op;
      entry_tok.timer_id     <= timer_id;
      entry_tok.duration_ms  <= duration_ms;
      entry_tok.new_id       <= id_counter + 16'd1;
      entry_tok.done         <= 1'b0;
      entry_tok.remaining_ms <= 32'd0;
      entry_tok.finished     <= 1'b0;
    end else if (advance) begin
      entry_tok.valid <= 1'b0;
    end
  end

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    ctb_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .advance     (advance),
      .tick_period (tick_period),
      .tok_in      (tok[g]),
      .tok_out     (tok[g+1])
    );
  end

  // busy flag, result register and id counter; result and id counter update when the item leaves the row
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      busy       <= 1'b0;
      id_counter <= 16'd0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (land) begin
        busy <= 1'b0;
      end
      if (land) begin
        out_valid    <= 1'b1;
        status       <= ST_OK;
        new_id       <= 16'd0;
        remaining_ms <= 32'd0;
        finished     <= 1'b0;
        unique case (tail.op)
          OP_ADD: begin
            if (tail.done) begin
              new_id     <= tail.new_id;
              id_counter <= tail.new_id;
            end else begin
              status <= ST_FULL;
            end
          end
          OP_QUERY: begin
            if (tail.done) begin
              remaining_ms <= tail.remaining_ms;
              finished     <= tail.finished;
            end else begin
              status <= ST_NOT_FOUND;
            end
          end
          OP_REMOVE, OP_RESET: begin
            if (!tail.done) begin
              status <= ST_NOT_FOUND;
            end
          end
          OP_CLEAR: begin
            id_counter <= 16'd0;
          end
          default: begin
          end
        endcase
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  for (genvar v = 0; v <= NUM_SLOTS; v++) begin : g_valids
    assign tok_valids[v] = tok[v].valid;
  end

  // at most one operation in the row at a time
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(tok_valids) <= 1)
    else $error("more than one operation in the cell row");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> tok[0].valid && busy)
    else $error("accepted item did not enter the row");

  a_full_no_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> new_id == 16'd0)
    else $error("full result carries an id");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> remaining_ms == 32'd0 && !finished)
    else $error("failed result carries data");

  a_finished_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && finished |-> remaining_ms == 32'd0 && status == ST_OK)
    else $error("finished with time left");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the countdown timer bank: directed and random operations.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ctb_pkg::*;

  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int LATE_ADDS = 6;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] timer_id;
    logic [31:0] duration_ms;
  } timer_cmd_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] new_id;
    logic [31:0] remaining_ms;
    logic        finished;
  } timer_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  op = '0;
  logic [15:0] timer_id = '0;
  logic [31:0] duration_ms = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [15:0] new_id;
  logic [31:0] remaining_ms;
  logic        finished;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  countdown_timer_bank dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .timer_id(timer_id),
    .duration_ms(duration_ms),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .new_id(new_id),
    .remaining_ms(remaining_ms),
    .finished(finished),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Predicted bank contents
  logic        exp_live [NUM_SLOTS] = '{default: 1'b0};
  logic [15:0] exp_id   [NUM_SLOTS] = '{default: '0};
  logic [31:0] exp_left [NUM_SLOTS] = '{default: '0};
  logic [15:0] exp_seq = '0;
  logic [15:0] exp_period = TICK_PERIOD_RESET;

  // Stimulus side bookkeeping of live ids, only to aim operations at real timers
  logic [15:0] gen_live [$];
  logic [15:0] gen_seq = '0;
  logic [15:0] gen_period = TICK_PERIOD_RESET;

  timer_cmd_t   cmd_backlog [$];
  timer_reply_t replies_due [$];
  timer_cmd_t   on_wire;
  timer_reply_t want;
  bit           idle_on = 1'b1;
  int           send_gap = 0;
  int           hold_gap = 0;
  int           mismatches = 0;
  int           cycle_count = 0;

  function automatic int first_live(logic [15:0] id);
    int k;
    k = -1;
    for (int i = NUM_SLOTS - 1; i >= 0; i--)
      if (exp_live[i] && exp_id[i] == id) k = i;
    return k;
  endfunction

  function automatic timer_reply_t predict_reply(timer_cmd_t c);
    timer_reply_t r;
    int k;
    bit hit;
    r = '0;
    r.status = ST_OK;
    k = -1;
    hit = 1'b0;
    case (c.op)
      OP_ADD: begin
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
          if (!exp_live[i]) k = i;
        if (k < 0) begin
          r.status = ST_FULL;
        end else begin
          exp_seq = exp_seq + 16'd1;
          exp_live[k] = 1'b1;
          exp_id[k] = exp_seq;
          exp_left[k] = c.duration_ms;
          r.new_id = exp_seq;
        end
      end
      OP_QUERY: begin
        k = first_live(c.timer_id);
        if (k < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.remaining_ms = exp_left[k];
          r.finished = (exp_left[k] == 0);
        end
      end
      OP_REMOVE: begin
        k = first_live(c.timer_id);
        if (k < 0) r.status = ST_NOT_FOUND;
        else exp_live[k] = 1'b0;
      end
      OP_RESET: begin
        // every slot carrying the id is reloaded
        for (int i = 0; i < NUM_SLOTS; i++)
          if (exp_live[i] && exp_id[i] == c.timer_id) begin
            exp_left[i] = c.duration_ms;
            hit = 1'b1;
          end
        if (!hit) r.status = ST_NOT_FOUND;
      end
      OP_TICK: begin
        for (int i = 0; i < NUM_SLOTS; i++)
          if (exp_live[i])
            exp_left[i] = (exp_left[i] > {16'd0, exp_period}) ?
                          exp_left[i] - {16'd0, exp_period} : 32'd0;
      end
      OP_CLEAR: begin
        for (int i = 0; i < NUM_SLOTS; i++) exp_live[i] = 1'b0;
        exp_seq = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void send(logic [2:0] c_op, logic [15:0] id, logic [31:0] dur);
    timer_cmd_t c;
    int hit;
    c.op = c_op;
    c.timer_id = id;
    c.duration_ms = dur;
    cmd_backlog = {cmd_backlog, c};
    hit = -1;
    case (c_op)
      OP_ADD: if (gen_live.size() < NUM_SLOTS) begin
        gen_seq = gen_seq + 16'd1;
        gen_live = {gen_live, gen_seq};
      end
      OP_REMOVE: begin
        for (int i = 0; i < gen_live.size(); i++)
          if (hit < 0 && gen_live[i] == id) hit = i;
        if (hit >= 0) gen_live.delete(hit);
      end
      OP_CLEAR: begin
        gen_live.delete();
        gen_seq = '0;
      end
      default: ;
    endcase
  endfunction

  function automatic void send_random(int add_pct, bit near_ids);
    logic [2:0]  c_op;
    logic [15:0] id;
    logic [31:0] dur;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < add_pct) begin
      c_op = OP_ADD;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 32) c_op = OP_QUERY;
      else if (pick < 50) c_op = OP_REMOVE;
      else if (pick < 66) c_op = OP_RESET;
      else if (pick < 92) c_op = OP_TICK;
      else if (pick < 96) c_op = OP_CLEAR;
      else c_op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    end
    if (gen_live.size() != 0 && $urandom_range(0, 9) < 8)
      id = gen_live[$urandom_range(0, gen_live.size() - 1)];
    else if (near_ids)
      id = 16'($urandom_range(0, 7));
    else
      id = 16'($urandom);
    // mostly durations a few ticks long so timers run out
    case ($urandom_range(0, 9))
      0: dur = '0;
      1: dur = '1;
      2, 3: dur = $urandom;
      default: dur = $urandom_range(0, 4 * gen_period + 1);
    endcase
    send(c_op, id, dur);
  endfunction

  task automatic settle();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || in_valid || replies_due.size() != 0);
  endtask

  task automatic set_period(input logic [15:0] p);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= p;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    exp_period = p;
    gen_period = p;
  endtask

  // Driver: a new command goes out once the previous one has transferred
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) replies_due = {replies_due, predict_reply(on_wire)};
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 17);
          in_valid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          on_wire = cmd_backlog.pop_front();
          in_valid <= 1'b1;
          op <= on_wire.op;
          timer_id <= on_wire.timer_id;
          duration_ms <= on_wire.duration_ms;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with none due: status %0d new_id %0d rem %0d fin %0d",
                     $realtime, status, new_id, remaining_ms, finished);
        end else begin
          want = replies_due.pop_front();
          if (status !== want.status || new_id !== want.new_id ||
              remaining_ms !== want.remaining_ms || finished !== want.finished) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: expected status %0d id %0d rem %0d fin %0d, got %0d %0d %0d %0d",
                       $realtime, want.status, want.new_id, want.remaining_ms, want.finished,
                       status, new_id, remaining_ms, finished);
          end
        end
      end
      if (hold_gap > 0) begin
        hold_gap--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        hold_gap = $urandom_range(0, 17);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [15:0] p;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset tick period, extremes, saturation, misses, spare codes, clear
    send(OP_ADD, 16'hFFFF, '0);
    send(OP_ADD, '0, 32'hFFFF_FFFF);
    send(OP_QUERY, 16'd1, '0);
    send(OP_QUERY, 16'd2, '0);
    send(OP_TICK, '0, '0);
    send(OP_QUERY, 16'd2, '0);
    send(OP_ADD, '0, 32'd700);
    send(OP_TICK, '0, '0);
    send(OP_QUERY, 16'd3, '0);
    send(OP_TICK, '0, '0);
    send(OP_QUERY, 16'd3, '0);
    send(OP_RESET, 16'd3, 32'd1234);
    send(OP_QUERY, 16'd3, '0);
    send(OP_REMOVE, 16'd1, '0);
    send(OP_QUERY, 16'd1, '0);
    send(OP_REMOVE, 16'd1, '0);
    send(OP_RESET, 16'd1, 32'hFFFF_FFFF);
    send(OP_SPARE_LO, 16'h5A5A, 32'hA5A5_A5A5);
    send(OP_SPARE_HI, 16'hFFFF, 32'hFFFF_FFFF);
    send(OP_QUERY, 16'hFFFF, '0);
    send(OP_CLEAR, '0, '0);
    send(OP_ADD, '0, 32'd1);
    send(OP_QUERY, 16'd1, '0);
    send(OP_QUERY, 16'd0, '0);
    settle();

    // Random phases, alternately filling and draining the bank
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: p = 16'd1;
        1: p = 16'hFFFF;
        2: p = 16'd0;
        3: p = 16'($urandom_range(2, 65534));
        4: p = TICK_PERIOD_RESET;
        default: p = 16'd9;
      endcase
      set_period(p);
      idle_on = (ph != 3);
      for (int n = 0; n < 140; n++) send_random((ph % 2 == 0) ? 60 : 25, 1'b0);
      settle();
    end

    // Last phase without idling: fresh bank, low ids so hits and misses mix
    set_period(16'd3);
    idle_on = 1'b0;
    send(OP_CLEAR, '0, '0);
    for (int n = 0; n < LATE_ADDS; n++) send(OP_ADD, 16'($urandom), $urandom_range(0, 40));
    for (int n = 0; n < 60; n++) send_random(20, 1'b1);
    settle();

    repeat (NUM_SLOTS + 4) @(posedge clk);
    if (mismatches == 0 && replies_due.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
